### rtl/core/sops_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sops_pkg
// Shared types and codes for the sparse offset predecessor search.
// ----------------------------------------------------------------------------
package sops_pkg;

	localparam int COUNT_W = 11;
	localparam int INDEX_W = 10;
	localparam int PORT_OFFSET_W = 32;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic wr;          // store one table entry
		logic load;        // open a query: bounds, target, best
		logic step;        // latch midpoint, read it
		logic eval_mid;    // judge midpoint read data
		logic eval_probe;  // judge leftward probe read data
		logic emit;        // register the result
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic more;        // lo < hi + 1
		logic rd_valid;    // entry just read has its valid mark
		logic mid_at_lo;   // midpoint sits on the low bound
		logic pos_at_lo;   // probe position sits on the low bound
	} status_t;

endpackage

### rtl/core/sops_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sops_ctrl
// Sequencer for table writes and the binary search with leftward probing.
// ----------------------------------------------------------------------------
module sops_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              op,
	input  sops_pkg::status_t st,
	output sops_pkg::cmd_t    cmd,
	output logic              busy,
	output logic              done
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_CHECK = 2'd1;
	localparam logic [1:0] S_MID   = 2'd2;
	localparam logic [1:0] S_PROBE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       done_q;

	always_comb begin
		cmd            = '0;
		cmd.wr         = (state_q == S_IDLE) && start && (op == sops_pkg::OP_WRITE);
		cmd.load       = (state_q == S_IDLE) && start && (op == sops_pkg::OP_QUERY);
		cmd.step       = (state_q == S_CHECK) && st.more;
		cmd.emit       = (state_q == S_CHECK) && !st.more;
		cmd.eval_mid   = (state_q == S_MID);
		cmd.eval_probe = (state_q == S_PROBE);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.load)
					state_d = S_CHECK;
			end
			S_CHECK: begin
				state_d = st.more ? S_MID : S_IDLE;
			end
			S_MID: begin
				state_d = (st.rd_valid || st.mid_at_lo) ? S_CHECK : S_PROBE;
			end
			S_PROBE: begin
				state_d = (st.rd_valid || st.pos_at_lo) ? S_CHECK : S_PROBE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.emit;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

### rtl/core/sops_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sops_dp
// Offset table memory, search bounds, compare and result registers.
// ----------------------------------------------------------------------------
module sops_dp #(
	parameter int MAX_ENTRIES = 1024,
	parameter int OFFSET_BITS = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  sops_pkg::cmd_t                       cmd,
	output sops_pkg::status_t                    st,
	input  logic                                 cfg_we,
	input  logic [sops_pkg::COUNT_W-1:0]         cfg_entry_count,
	input  logic [sops_pkg::INDEX_W-1:0]         entry_index,
	input  logic [sops_pkg::PORT_OFFSET_W-1:0]   entry_offset,
	input  logic                                 entry_valid,
	input  logic [sops_pkg::PORT_OFFSET_W-1:0]   query_offset,
	output logic                                 found,
	output logic [sops_pkg::INDEX_W-1:0]         node_index
);

	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int OB = OFFSET_BITS;
	localparam int PW = sops_pkg::PORT_OFFSET_W;
	localparam int XW = sops_pkg::INDEX_W;

	// entry: {valid, offset}
	logic [OB:0]                      mem_q [MAX_ENTRIES];
	logic [OB:0]                      rd_data_q;
	logic [sops_pkg::COUNT_W-1:0]     entry_count_q;
	logic [OB-1:0]                    target_q;
	logic [CW-1:0]                    lo_q;
	logic [CW-1:0]                    hix_q;    // one past the high bound
	logic [IW-1:0]                    mid_q;
	logic [IW-1:0]                    pos_q;
	logic [IW-1:0]                    best_q;
	logic                             best_found_q;
	logic                             found_q;
	logic [XW-1:0]                    node_index_q;

	logic [CW-1:0]                    n_eff;
	logic [CW-1:0]                    span;
	logic [IW-1:0]                    mid_c;
	logic [CW-1:0]                    mid_inc;
	logic [IW-1:0]                    rd_addr;
	logic                             rd_vld;
	logic                             rd_le;
	logic [IW+XW-1:0]                 wr_ext;
	logic [IW+XW-1:0]                 best_ext;
	logic [OB+PW-1:0]                 woff_ext;
	logic [OB+PW-1:0]                 qoff_ext;
	logic                             wr_in_range;

	always_comb begin
		n_eff   = (32'(entry_count_q) > MAX_ENTRIES) ? CW'(MAX_ENTRIES)
		                                              : CW'(entry_count_q);
		span    = CW'(hix_q - lo_q - CW'(1));
		mid_c   = IW'(lo_q + (span >> 1));
		mid_inc = CW'(mid_q) + CW'(1);
		rd_vld  = rd_data_q[OB];
		rd_le   = (rd_data_q[OB-1:0] <= target_q);

		wr_ext      = {{IW{1'b0}}, entry_index};
		best_ext    = {{XW{1'b0}}, best_q};
		woff_ext    = {{OB{1'b0}}, entry_offset};
		qoff_ext    = {{OB{1'b0}}, query_offset};
		wr_in_range = (32'(entry_index) < MAX_ENTRIES);

		if (cmd.eval_mid)
			rd_addr = mid_q - IW'(1);
		else if (cmd.eval_probe)
			rd_addr = pos_q - IW'(1);
		else
			rd_addr = mid_c;
	end

	always_comb begin
		st.more      = (lo_q < hix_q);
		st.rd_valid  = rd_vld;
		st.mid_at_lo = (CW'(mid_q) == lo_q);
		st.pos_at_lo = (CW'(pos_q) == lo_q);
	end

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.wr && wr_in_range)
			mem_q[wr_ext[IW-1:0]] <= {entry_valid, woff_ext[OB-1:0]};
		rd_data_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (cfg_we) begin
			entry_count_q <= cfg_entry_count;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lo_q         <= '0;
			hix_q        <= n_eff;
			best_q       <= '0;
			best_found_q <= 1'b0;
			target_q     <= qoff_ext[OB-1:0];
		end
		if (cmd.step)
			mid_q <= mid_c;
		if (cmd.eval_mid) begin
			if (rd_vld) begin
				if (rd_le) begin
					best_q       <= mid_q;
					best_found_q <= 1'b1;
					lo_q         <= mid_inc;
				end else begin
					hix_q <= CW'(mid_q);
				end
			end else if (st.mid_at_lo) begin
				lo_q <= mid_inc;
			end else begin
				pos_q <= mid_q - IW'(1);
			end
		end
		if (cmd.eval_probe) begin
			if (rd_vld) begin
				if (rd_le) begin
					best_q       <= pos_q;
					best_found_q <= 1'b1;
					lo_q         <= mid_inc;
				end else begin
					hix_q <= CW'(pos_q);
				end
			end else if (st.pos_at_lo) begin
				// nothing valid left of mid: go right
				lo_q <= mid_inc;
			end else begin
				pos_q <= pos_q - IW'(1);
			end
		end
		if (cmd.emit) begin
			found_q      <= best_found_q;
			node_index_q <= best_found_q ? best_ext[XW-1:0] : '0;
		end
	end

	assign found      = found_q;
	assign node_index = node_index_q;

endmodule

### rtl/core/sparse_offset_predecessor_search_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_offset_predecessor_search_top
// A write leaves busy low. A query holds busy high through its binary
//   search steps and leftward probe reads, until the result is registered.
//   One item at a time.
// The single-port table read (one entry per read, registered) sets the pace.
// Reset clears the controller and entry_count; table contents are kept.
// done marks a one-cycle result beat; the receiver cannot stall.
// ----------------------------------------------------------------------------
module sparse_offset_predecessor_search_top #(
	parameter int MAX_ENTRIES = 1024,
	parameter int OFFSET_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                op,
	input  logic [sops_pkg::INDEX_W-1:0]        entry_index,
	input  logic [sops_pkg::PORT_OFFSET_W-1:0]  entry_offset,
	input  logic                                entry_valid,
	input  logic [sops_pkg::PORT_OFFSET_W-1:0]  query_offset,
	output logic                                done,
	output logic                                found,
	output logic [sops_pkg::INDEX_W-1:0]        node_index,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [sops_pkg::COUNT_W-1:0]        cfg_data
);

	sops_pkg::cmd_t    cmd;
	sops_pkg::status_t st;

	assign cfg_ready = 1'b1;

	sops_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	sops_dp #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.OFFSET_BITS (OFFSET_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.cfg_we          (cfg_valid & cfg_ready),
		.cfg_entry_count (cfg_data),
		.entry_index     (entry_index),
		.entry_offset    (entry_offset),
		.entry_valid     (entry_valid),
		.query_offset    (query_offset),
		.found           (found),
		.node_index      (node_index)
	);

endmodule

### bench/tb_sparse_offset_predecessor_search_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sparse_offset_predecessor_search_top
// Self-checking bench for the sparse offset predecessor search. A queue of
// table writes, queries and entry_count updates is built up front. A clocked
// driver plays it out with random gaps and keeps a shadow table. Each query
// beat is answered by the shadow search and checked against the done beat.
// ----------------------------------------------------------------------------
module tb_sparse_offset_predecessor_search_top;

	localparam int TABLE_SLOTS   = 1024;
	localparam int COUNT_MAX     = (1 << sops_pkg::COUNT_W) - 1;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES  = 64;
	localparam int QUIET_LIMIT   = 8000;
	localparam int RANDOM_ITEMS  = 200;

	typedef enum logic {BEAT_ITEM, BEAT_CFG} beat_kind_t;

	typedef enum int {
		LAYOUT_DENSE, LAYOUT_HALF, LAYOUT_SPARSE, LAYOUT_EMPTY, LAYOUT_RUNS
	} layout_t;

	typedef struct {
		beat_kind_t                          kind;
		logic                                op;
		logic [sops_pkg::INDEX_W-1:0]        slot;
		logic [sops_pkg::PORT_OFFSET_W-1:0]  off;
		logic                                valid_mark;
		logic [sops_pkg::PORT_OFFSET_W-1:0]  target;
		logic [sops_pkg::COUNT_W-1:0]        count;
	} beat_t;

	typedef struct packed {
		logic                         found;
		logic [sops_pkg::INDEX_W-1:0] node_index;
	} answer_t;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                start = 1'b0;
	logic                                busy;
	logic                                op = sops_pkg::OP_WRITE;
	logic [sops_pkg::INDEX_W-1:0]        entry_index = '0;
	logic [sops_pkg::PORT_OFFSET_W-1:0]  entry_offset = '0;
	logic                                entry_valid = 1'b0;
	logic [sops_pkg::PORT_OFFSET_W-1:0]  query_offset = '0;
	logic                                done;
	logic                                found;
	logic [sops_pkg::INDEX_W-1:0]        node_index;
	logic                                cfg_valid = 1'b0;
	logic                                cfg_ready;
	logic [sops_pkg::COUNT_W-1:0]        cfg_data = '0;

	beat_t   pending_beats[$];
	answer_t answer_q[$];

	// shadow of the block, updated on accepted beats
	logic [sops_pkg::PORT_OFFSET_W-1:0] tbl_offset [TABLE_SLOTS];
	bit                                 tbl_valid [TABLE_SLOTS];
	logic [sops_pkg::COUNT_W-1:0]       used_count;

	// what the stimulus builder has laid out so far
	logic [sops_pkg::PORT_OFFSET_W-1:0] gen_offset [TABLE_SLOTS];
	bit                                 gen_valid [TABLE_SLOTS];
	bit                                 gen_written [TABLE_SLOTS];
	int                                 laid_extent = 0;
	int unsigned                        items_built = 0;

	int unsigned idle_left, settle_left, calm_left;
	int unsigned quiet_cycles = 0;
	int unsigned fault_count = 0;

	always #1 clk = ~clk;

	sparse_offset_predecessor_search_top #(
		.MAX_ENTRIES(TABLE_SLOTS),
		.OFFSET_BITS(sops_pkg::PORT_OFFSET_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.entry_index(entry_index),
		.entry_offset(entry_offset),
		.entry_valid(entry_valid),
		.query_offset(query_offset),
		.done(done),
		.found(found),
		.node_index(node_index),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	function automatic void note_fault(string msg);
		fault_count++;
		if (fault_count <= 10) $display("%0t: %s", $time, msg);
	endfunction

	// last valid slot at or below target; unset midpoints probe leftward
	function automatic int predecessor_of(logic [sops_pkg::PORT_OFFSET_W-1:0] target);
		int n, lo, hi, mid, p, best;
		n = (used_count > TABLE_SLOTS) ? TABLE_SLOTS : int'(used_count);
		lo = 0;
		hi = n - 1;
		best = -1;
		while (lo <= hi) begin
			mid = lo + (hi - lo) / 2;
			if (tbl_valid[mid]) begin
				if (tbl_offset[mid] <= target) begin
					best = mid;
					lo = mid + 1;
				end else
					hi = mid - 1;
			end else begin
				p = mid - 1;
				while (p >= lo && !tbl_valid[p])
					p--;
				if (p < lo)
					lo = mid + 1;
				else if (tbl_offset[p] <= target) begin
					best = p;
					lo = mid + 1;
				end else
					hi = p - 1;
			end
		end
		return best;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (calm_left != 0) begin
			calm_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			calm_left = $urandom_range(20, 60);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	task automatic push_write(int slot, logic [sops_pkg::PORT_OFFSET_W-1:0] off, logic mark);
		beat_t b;
		b.kind = BEAT_ITEM;
		b.op = sops_pkg::OP_WRITE;
		b.slot = sops_pkg::INDEX_W'(slot);
		b.off = off;
		b.valid_mark = mark;
		b.target = $urandom();
		b.count = '0;
		pending_beats.push_back(b);
		gen_offset[slot] = off;
		gen_valid[slot] = mark;
		gen_written[slot] = 1'b1;
		while (laid_extent < TABLE_SLOTS && gen_written[laid_extent])
			laid_extent++;
		items_built++;
	endtask

	task automatic push_query(logic [sops_pkg::PORT_OFFSET_W-1:0] target);
		beat_t b;
		b.kind = BEAT_ITEM;
		b.op = sops_pkg::OP_QUERY;
		b.slot = sops_pkg::INDEX_W'($urandom());
		b.off = $urandom();
		b.valid_mark = 1'($urandom_range(0, 1));
		b.target = target;
		b.count = '0;
		pending_beats.push_back(b);
		items_built++;
	endtask

	task automatic push_count(int n);
		beat_t b;
		b.kind = BEAT_CFG;
		b.op = sops_pkg::OP_WRITE;
		b.slot = '0;
		b.off = '0;
		b.valid_mark = 1'b0;
		b.target = '0;
		b.count = sops_pkg::COUNT_W'(n);
		pending_beats.push_back(b);
	endtask

	// rising offsets over slots 0..n-1, with an occasional out-of-order one
	task automatic lay_out_table(int n, layout_t style);
		int last;
		logic [63:0] acc;
		int unsigned stride_max;
		logic mark;
		last = (n > TABLE_SLOTS) ? TABLE_SLOTS : n;
		case ($urandom_range(0, 3))
			0: stride_max = 3;
			1: stride_max = 1000;
			2: stride_max = 1 << 20;
			default: stride_max = 1 << 28;
		endcase
		case ($urandom_range(0, 2))
			0: acc = 64'd0;
			1: acc = 64'($urandom_range(0, 4096));
			default: acc = 64'($urandom());
		endcase
		mark = 1'b1;
		for (int k = 0; k < last; k++) begin
			case (style)
				LAYOUT_DENSE: mark = 1'b1;
				LAYOUT_HALF: mark = 1'($urandom_range(0, 1));
				LAYOUT_SPARSE: mark = ($urandom_range(0, 7) == 0);
				LAYOUT_EMPTY: mark = 1'b0;
				default: if ($urandom_range(0, 7) == 0) mark = !mark;
			endcase
			if ($urandom_range(0, 49) == 0)
				push_write(k, $urandom(), mark);
			else
				push_write(k, (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0], mark);
			acc += $urandom_range(0, stride_max);
		end
	endtask

	// targets near stored offsets, at the extremes and random; a few writes mixed in
	task automatic probe_queries(int n, int how_many);
		int last, k;
		logic [sops_pkg::PORT_OFFSET_W-1:0] t;
		last = (n > TABLE_SLOTS) ? TABLE_SLOTS : n;
		repeat (how_many) begin
			case ($urandom_range(0, 6))
				0: t = '0;
				1: t = 32'hFFFF_FFFF;
				2: t = $urandom();
				default: begin
					if (last == 0)
						t = $urandom();
					else begin
						k = $urandom_range(0, last - 1);
						t = gen_offset[k] + $urandom_range(0, 2) - 1;
					end
				end
			endcase
			if ($urandom_range(0, 5) == 0) begin
				k = $urandom_range(0, TABLE_SLOTS - 1);
				// flipping the mark keeps the offsets in order
				if (k < last)
					push_write(k, gen_offset[k], !gen_valid[k]);
				else
					push_write(k, $urandom(), 1'($urandom_range(0, 1)));
			end
			push_query(t);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : driver
		logic raise_start, raise_cfg;
		int best;
		beat_t nxt;
		answer_t a;
		if (!arst_n) begin
			start <= 1'b0;
			op <= sops_pkg::OP_WRITE;
			entry_index <= '0;
			entry_offset <= '0;
			entry_valid <= 1'b0;
			query_offset <= '0;
			cfg_valid <= 1'b0;
			cfg_data <= '0;
			idle_left = 0;
			settle_left = 0;
			calm_left = 0;
			used_count = '0;
		end else begin
			raise_start = start;
			raise_cfg = cfg_valid;
			if (start && !busy) begin
				raise_start = 1'b0;
				if (op == sops_pkg::OP_WRITE) begin
					tbl_offset[entry_index] = entry_offset;
					tbl_valid[entry_index] = entry_valid;
				end else begin
					best = predecessor_of(query_offset);
					if (best < 0)
						a = '{1'b0, '0};
					else
						a = '{1'b1, sops_pkg::INDEX_W'(best)};
					answer_q.push_back(a);
				end
				idle_left = pick_gap();
				settle_left = SETTLE_CYCLES;
			end else if (cfg_valid && cfg_ready) begin
				raise_cfg = 1'b0;
				used_count = cfg_data;
				idle_left = pick_gap();
			end else begin
				if (settle_left != 0)
					settle_left--;
				if (idle_left != 0 && !start && !cfg_valid)
					idle_left--;
			end
			if (!raise_start && !raise_cfg && idle_left == 0 && pending_beats.size() != 0) begin
				nxt = pending_beats[0];
				if (nxt.kind == BEAT_CFG) begin
					// entry_count changes only once the block has gone quiet
					if (answer_q.size() == 0 && settle_left == 0 && !busy) begin
						cfg_data <= nxt.count;
						raise_cfg = 1'b1;
						void'(pending_beats.pop_front());
					end
				end else begin
					op <= nxt.op;
					entry_index <= nxt.slot;
					entry_offset <= nxt.off;
					entry_valid <= nxt.valid_mark;
					query_offset <= nxt.target;
					raise_start = 1'b1;
					void'(pending_beats.pop_front());
				end
			end
			start <= raise_start;
			cfg_valid <= raise_cfg;
		end
	end

	always @(posedge clk) begin : monitor
		answer_t want;
		if (arst_n && done) begin
			if (answer_q.size() == 0)
				note_fault($sformatf("result beat with nothing pending: found %0b node_index %0d",
					found, node_index));
			else begin
				want = answer_q.pop_front();
				if (found !== want.found)
					note_fault($sformatf("found mismatch: expected %0b, got %0b",
						want.found, found));
				if (node_index !== want.node_index)
					note_fault($sformatf("node_index mismatch: expected %0d, got %0d",
						want.node_index, node_index));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || (cfg_valid && cfg_ready) || done)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("no beat moved for %0d cycles", QUIET_LIMIT);
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		int n;
		int unsigned rand_start;

		// empty table
		push_count(0);
		push_query('0);
		push_query(32'hFFFF_FFFF);

		push_write(0, '0, 1'b1);
		push_write(1, 32'd5, 1'b0);
		push_write(2, 32'd100, 1'b1);
		push_write(3, 32'd200, 1'b0);
		push_write(4, 32'd300, 1'b0);
		push_write(5, 32'hFFFF_FFFF, 1'b1);
		push_write(TABLE_SLOTS - 1, 32'hFFFF_FFFF, 1'b0);
		push_count(6);
		push_query('0);
		push_query(32'd99);
		push_query(32'd100);
		push_query(32'hFFFF_FFFE);
		push_query(32'hFFFF_FFFF);

		// leftward probe that reaches the low bound with nothing found
		push_write(0, '0, 1'b0);
		push_count(4);
		push_query(32'd50);
		push_query(32'd200);
		push_count(1);
		push_query('0);
		push_count(6);
		push_query(32'h8000_0000);

		// whole table, counts at and past the table size
		lay_out_table(TABLE_SLOTS, LAYOUT_SPARSE);
		push_count(TABLE_SLOTS);
		probe_queries(TABLE_SLOTS, 10);
		push_count(COUNT_MAX);
		probe_queries(TABLE_SLOTS, 6);
		push_count(TABLE_SLOTS + 1);
		probe_queries(TABLE_SLOTS, 10);

		rand_start = items_built;
		while (items_built - rand_start < RANDOM_ITEMS) begin
			if (laid_extent != 0 && $urandom_range(0, 3) == 0)
				n = $urandom_range(1, (laid_extent > 200) ? 200 : laid_extent);
			else begin
				case ($urandom_range(0, 9))
					0: n = 0;
					1: n = 1;
					2: n = 2;
					8: n = $urandom_range(41, 160);
					default: n = $urandom_range(3, 40);
				endcase
				lay_out_table(n, layout_t'($urandom_range(0, 4)));
			end
			push_count(n);
			probe_queries(n, $urandom_range(6, 24));
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_beats.size() != 0 || answer_q.size() != 0 || start || cfg_valid)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (fault_count == 0 && answer_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### sparse_offset_predecessor_search_top.f
rtl/core/sops_pkg.sv
rtl/core/sops_ctrl.sv
rtl/core/sops_dp.sv
rtl/core/sparse_offset_predecessor_search_top.sv
bench/tb_sparse_offset_predecessor_search_top.sv
